[design/gain_event_stream_checker_assert.svh]
// ----------------------------------------------------------------------------
// Gain event stream checker assertion macros
// Concurrent assertion helpers used by the top RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef GAIN_EVENT_STREAM_CHECKER_ASSERT_SVH
`define GAIN_EVENT_STREAM_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define GESC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GESC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define GESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/gesc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain event stream checker package
// Types, result codes and limits shared by the checker modules.
// ----------------------------------------------------------------------------
package gesc_pkg;

    localparam logic [6:0]  MAX_FORWARD    = 7'd64;
    localparam logic [7:0]  GAIN_MAX       = 8'h7f;
    localparam logic [15:0] FLAGS_RESERVED = 16'hffc0;
    localparam logic [3:0]  CAUSE_MAX      = 4'd6;
    localparam logic [1:0]  KIND_FIRST     = 2'd1;
    localparam logic [1:0]  KIND_LAST      = 2'd2;

    // Register indexes of the configuration port.
    localparam logic CFG_START_GAIN  = 1'b0;
    localparam logic CFG_START_COUNT = 1'b1;

    typedef enum logic {
        OP_BEGIN_FRAME = 1'b0,
        OP_GAIN_EVENT  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        V_FORWARDED  = 4'd0,
        V_CONSUMED   = 4'd1,
        V_DEFERRED   = 4'd2,
        V_GAP        = 4'd3,
        V_REGRESSION = 4'd4,
        V_BAD        = 4'd5,
        V_FULL       = 4'd6,
        V_RANGE      = 4'd7,
        V_FRAME_OK   = 4'd8
    } verdict_t;

    typedef struct packed {
        op_t         operation;
        logic [63:0] frame_start;
        logic [31:0] frame_length;
        logic [6:0]  frame_capacity;
        logic [63:0] sample_stamp;
        logic [31:0] event_number;
        logic [15:0] event_flags;
        logic [7:0]  gain_first;
        logic [7:0]  gain_second;
    } item_t;

    typedef struct packed {
        logic [31:0] next_event_number;
        logic        event_number_known;
        logic [63:0] last_stamp;
        logic        stamp_known;
        logic [6:0]  gain_now;
        logic [31:0] transitions;
        logic [63:0] window_start;
        logic [63:0] window_end;
        logic [6:0]  window_capacity;
        logic [6:0]  window_forwarded;
    } state_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [6:0]  current_gain;
        logic [31:0] transition_total;
        logic [6:0]  forwarded_count;
    } result_t;

endpackage

[design/gesc_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain event stream checker evaluation
// Combinational verdict and next tracking state for one item.
// ----------------------------------------------------------------------------
module gesc_eval (
    input  gesc_pkg::item_t   item,
    input  gesc_pkg::state_t  state,
    output gesc_pkg::state_t  state_next,
    output gesc_pkg::result_t result
);

    always_comb
    begin
        logic [64:0] end_sum;
        logic [6:0]  cap_sat;
        logic [1:0]  kind;
        logic        bad;
        logic        in_window;
        gesc_pkg::verdict_t verdict;

        state_next = state;
        end_sum = {1'b0, item.frame_start} + {33'b0, item.frame_length};
        cap_sat = (item.frame_capacity > gesc_pkg::MAX_FORWARD) ?
                  gesc_pkg::MAX_FORWARD : item.frame_capacity;
        kind = item.event_flags[5:4];
        bad = (item.gain_first != item.gain_second)
            || (item.gain_first > gesc_pkg::GAIN_MAX)
            || ((item.event_flags & gesc_pkg::FLAGS_RESERVED) != 16'd0)
            || (kind < gesc_pkg::KIND_FIRST) || (kind > gesc_pkg::KIND_LAST)
            || (item.event_flags[3:0] > gesc_pkg::CAUSE_MAX);
        in_window = (item.sample_stamp >= state.window_start);

        if (item.operation == gesc_pkg::OP_BEGIN_FRAME)
        begin
            // A frame whose end does not fit in 64 bits, or an empty one, is refused.
            if ((item.frame_length == 32'd0) || end_sum[64])
            begin
                verdict = gesc_pkg::V_RANGE;
            end
            else
            begin
                state_next.window_start     = item.frame_start;
                state_next.window_end       = end_sum[63:0];
                state_next.window_capacity  = cap_sat;
                state_next.window_forwarded = 7'd0;
                verdict = gesc_pkg::V_FRAME_OK;
            end
        end
        else if (item.sample_stamp >= state.window_end)
        begin
            verdict = gesc_pkg::V_DEFERRED;
        end
        else if (state.event_number_known && (item.event_number != state.next_event_number))
        begin
            verdict = gesc_pkg::V_GAP;
        end
        else if (state.stamp_known && (item.sample_stamp < state.last_stamp))
        begin
            verdict = gesc_pkg::V_REGRESSION;
        end
        else if (bad)
        begin
            verdict = gesc_pkg::V_BAD;
        end
        else if (in_window && (state.window_forwarded >= state.window_capacity))
        begin
            verdict = gesc_pkg::V_FULL;
        end
        else
        begin
            state_next.next_event_number  = item.event_number + 32'd1;
            state_next.event_number_known = 1'b1;
            state_next.last_stamp         = item.sample_stamp;
            state_next.stamp_known        = 1'b1;
            state_next.gain_now           = item.gain_first[6:0];
            state_next.transitions        = state.transitions + 32'd1;
            if (in_window)
            begin
                state_next.window_forwarded = state.window_forwarded + 7'd1;
                verdict = gesc_pkg::V_FORWARDED;
            end
            else
            begin
                verdict = gesc_pkg::V_CONSUMED;
            end
        end

        result.verdict          = verdict;
        result.current_gain     = state_next.gain_now;
        result.transition_total = state_next.transitions;
        result.forwarded_count  = state_next.window_forwarded;
    end

endmodule

[design/gain_event_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain event stream checker
// Checks receive-gain change events against a frame window of sample stamps.
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: s_tuser selects a begin-frame item (0) or a
// gain event (1), and s_tdata carries the frame and event fields. Every item
// gives exactly one result transfer on the m_ stream with a verdict, the
// tracked gain, the transition total and the count forwarded in this frame.
// An accepted item sits in the input register while it is checked against
// the tracking state; its result and the new state are loaded together into
// the output register and the state register when the output register is free.
// The block takes one item per clock cycle while the receiver takes results;
// the check itself is three 64-bit compares and one 64-bit add for the frame end.
// If the receiver stalls, the result holds in the output register and the
// input register still takes one more item, after which s_tready drops.
// The configuration port loads the start gain and transition count and must be
// written only while the block is idle; the block does not enforce this. Reset
// clears all tracking state: every event defers until a begin-frame opens a window.
// ----------------------------------------------------------------------------
`include "gain_event_stream_checker_assert.svh"

module gain_event_stream_checker (
    input  logic         clk,
    input  logic         rst_n,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: frame_start[63:0], frame_length[31:0],
    // frame_capacity[6:0], sample_stamp[63:0], event_number[31:0],
    // event_flags[15:0], gain_first[7:0], gain_second[7:0], one zero pad bit.
    input  logic [231:0] s_tdata,
    // tuser: operation (0 begin frame, 1 gain event).
    input  logic         s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: verdict[3:0], current_gain[6:0],
    // transition_total[31:0], forwarded_count[6:0], six zero pad bits.
    output logic [55:0]  m_tdata,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    logic               in_valid_reg;
    gesc_pkg::item_t    in_item_reg;
    logic               out_valid_reg;
    gesc_pkg::result_t  out_result_reg;
    gesc_pkg::state_t   state_reg;
    gesc_pkg::state_t   state_next;
    gesc_pkg::state_t   eval_state;
    gesc_pkg::result_t  eval_result;
    logic               advance;
    logic               in_load;

    // The held item moves to the output register when that register is free
    // or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    gesc_eval u_eval (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (eval_state),
        .result     (eval_result)
    );

    // Configuration is to be written only while idle; the block does not enforce this. A write takes priority.
    always_comb
    begin
        state_next = advance ? eval_state : state_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gesc_pkg::CFG_START_GAIN:  state_next.gain_now    = cfg_data[6:0];
                gesc_pkg::CFG_START_COUNT: state_next.transitions = cfg_data;
                default:                   state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.operation      <= gesc_pkg::op_t'(s_tuser);
            in_item_reg.frame_start    <= s_tdata[63:0];
            in_item_reg.frame_length   <= s_tdata[95:64];
            in_item_reg.frame_capacity <= s_tdata[102:96];
            in_item_reg.sample_stamp   <= s_tdata[166:103];
            in_item_reg.event_number   <= s_tdata[198:167];
            in_item_reg.event_flags    <= s_tdata[214:199];
            in_item_reg.gain_first     <= s_tdata[222:215];
            in_item_reg.gain_second    <= s_tdata[230:223];
        end
        if (advance)
        begin
            out_result_reg <= eval_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_result_reg.forwarded_count,
                       out_result_reg.transition_total,
                       out_result_reg.current_gain,
                       out_result_reg.verdict};

    // The forwarded count never passes the frame capacity, which is saturated.
    `GESC_ASSERT_SAME(a_fwd_within_cap, clk, rst_n, 1'b1, state_reg.window_forwarded <= state_reg.window_capacity, "forwarded count above capacity")
    `GESC_ASSERT_SAME(a_cap_saturated, clk, rst_n, 1'b1, state_reg.window_capacity <= gesc_pkg::MAX_FORWARD, "capacity above forward limit")
    // Tracking state only moves when an item is retired or a register is written.
    `GESC_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance && !cfg_we, $stable(state_reg), "state changed without an item")
    // An item steps the transition count by at most one.
    `GESC_ASSERT_NEXT(a_trans_step, clk, rst_n, advance && !cfg_we, (state_reg.transitions == $past(state_reg.transitions)) || (state_reg.transitions == $past(state_reg.transitions) + 32'd1), "transition count jumped")
    // Once a stamp has been seen it stays known until reset.
    `GESC_ASSERT_NEXT(a_stamp_known_sticks, clk, rst_n, state_reg.stamp_known, state_reg.stamp_known, "stamp knowledge lost")

endmodule

[dv/tb_gain_event_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain event stream checker testbench
// Drives begin-frame and gain-event transfers into the checker and compares
// every result transfer with a cycle-free prediction of the block, under
// random idling on both streams and several start register settings.
// ----------------------------------------------------------------------------
module tb_gain_event_stream_checker;

    localparam int unsigned PHASE_ITEMS     = 150;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    // Extra settle time after the last result keeps any register write clear
    // of the pipeline.
    localparam int unsigned SETTLE_CYCLES   = 4;
    // The limit leaves plenty of margin for long stalls on both sides.
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the checker state, predicts one result per accepted
    // item and holds those results until the matching output transfer.
    // ------------------------------------------------------------------------
    class gain_verdict_board;
        logic [6:0]        start_gain;
        logic [31:0]       start_count;
        gesc_pkg::state_t  track;
        gesc_pkg::result_t expected_q[$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       verdict_hits[9];

        function new();
            start_gain   = '0;
            start_count  = '0;
            track        = '0;
            mismatches   = 0;
            results_seen = 0;
            foreach (verdict_hits[i])
                verdict_hits[i] = 0;
        endfunction

        // A register write also reloads the tracked copy it seeds.
        function void write_register(logic index, logic [31:0] value);
            if (index == gesc_pkg::CFG_START_GAIN)
            begin
                start_gain     = value[6:0];
                track.gain_now = value[6:0];
            end
            else
            begin
                start_count       = value;
                track.transitions = value;
            end
        endfunction

        function void note_transfer(gesc_pkg::item_t it);
            gesc_pkg::result_t r;
            logic [64:0]       end_sum;
            logic [1:0]        kind;
            logic              bad;
            logic              in_window;

            if (it.operation == gesc_pkg::OP_BEGIN_FRAME)
            begin
                // The carry out of the 64-bit end marks a frame that wraps.
                end_sum = {1'b0, it.frame_start} + {33'd0, it.frame_length};
                if (it.frame_length == '0 || end_sum[64])
                begin
                    r.verdict = gesc_pkg::V_RANGE;
                end
                else
                begin
                    track.window_start     = it.frame_start;
                    track.window_end       = end_sum[63:0];
                    track.window_capacity  = (it.frame_capacity > gesc_pkg::MAX_FORWARD) ?
                                             gesc_pkg::MAX_FORWARD : it.frame_capacity;
                    track.window_forwarded = '0;
                    r.verdict              = gesc_pkg::V_FRAME_OK;
                end
            end
            else
            begin
                kind = it.event_flags[5:4];
                bad  = (it.gain_first != it.gain_second) ||
                       (it.gain_first > gesc_pkg::GAIN_MAX) ||
                       ((it.event_flags & gesc_pkg::FLAGS_RESERVED) != '0) ||
                       (kind < gesc_pkg::KIND_FIRST) || (kind > gesc_pkg::KIND_LAST) ||
                       (it.event_flags[3:0] > gesc_pkg::CAUSE_MAX);
                in_window = (it.sample_stamp >= track.window_start);

                // Checks run in a fixed order and the first failure wins.
                if (it.sample_stamp >= track.window_end)
                    r.verdict = gesc_pkg::V_DEFERRED;
                else if (track.event_number_known &&
                         it.event_number != track.next_event_number)
                    r.verdict = gesc_pkg::V_GAP;
                else if (track.stamp_known && it.sample_stamp < track.last_stamp)
                    r.verdict = gesc_pkg::V_REGRESSION;
                else if (bad)
                    r.verdict = gesc_pkg::V_BAD;
                else if (in_window && track.window_forwarded >= track.window_capacity)
                    r.verdict = gesc_pkg::V_FULL;
                else
                begin
                    track.next_event_number  = it.event_number + 32'd1;
                    track.event_number_known = 1'b1;
                    track.last_stamp         = it.sample_stamp;
                    track.stamp_known        = 1'b1;
                    track.gain_now           = it.gain_first[6:0];
                    track.transitions        = track.transitions + 32'd1;
                    if (in_window)
                    begin
                        track.window_forwarded = track.window_forwarded + 7'd1;
                        r.verdict              = gesc_pkg::V_FORWARDED;
                    end
                    else
                    begin
                        r.verdict = gesc_pkg::V_CONSUMED;
                    end
                end
            end

            r.current_gain     = track.gain_now;
            r.transition_total = track.transitions;
            r.forwarded_count  = track.window_forwarded;
            expected_q.push_back(r);
        endfunction

        // Result tdata from bit 0: verdict, current_gain, transition_total,
        // forwarded_count.
        function void check_result(logic [55:0] bus);
            gesc_pkg::result_t want;

            if (expected_q.size() == 0)
            begin
                $error("result transfer with no item outstanding: tdata=%h", bus);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            verdict_hits[int'(want.verdict)]++;
            if (bus[3:0] != want.verdict)
            begin
                $error("verdict: expected %0d, got %0d", want.verdict, bus[3:0]);
                mismatches++;
            end
            if (bus[10:4] != want.current_gain)
            begin
                $error("current_gain: expected %0d, got %0d", want.current_gain, bus[10:4]);
                mismatches++;
            end
            if (bus[42:11] != want.transition_total)
            begin
                $error("transition_total: expected %0d, got %0d",
                       want.transition_total, bus[42:11]);
                mismatches++;
            end
            if (bus[49:43] != want.forwarded_count)
            begin
                $error("forwarded_count: expected %0d, got %0d",
                       want.forwarded_count, bus[49:43]);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and its connections.
    // ------------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [231:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         cfg_we;
    logic         cfg_index;
    logic [31:0]  cfg_data;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gain_event_stream_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gain_verdict_board board = new();

    // Idling controls shared by the sender and the receiver. They change only
    // between phases, except for the one-shot receiver hold-off request.
    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_off_req   = 1'b0;
    int unsigned frames_sent    = 0;
    int unsigned events_sent    = 0;

    // Most gaps are short; about one in five is a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Item builders. Fields that an item does not use still carry random
    // content so the block is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic gesc_pkg::item_t random_item();
        logic [255:0] noise;

        for (int i = 0; i < 8; i++)
            noise[i*32 +: 32] = $urandom;
        return gesc_pkg::item_t'(noise[231:0]);
    endfunction

    function automatic gesc_pkg::item_t frame_item(logic [63:0] start, logic [31:0] len,
                                                   logic [6:0] cap);
        gesc_pkg::item_t it;

        it                = random_item();
        it.operation      = gesc_pkg::OP_BEGIN_FRAME;
        it.frame_start    = start;
        it.frame_length   = len;
        it.frame_capacity = cap;
        return it;
    endfunction

    function automatic gesc_pkg::item_t event_item(logic [63:0] stamp, logic [31:0] number,
                                                   logic [15:0] flags, logic [7:0] g1,
                                                   logic [7:0] g2);
        gesc_pkg::item_t it;

        it              = random_item();
        it.operation    = gesc_pkg::OP_GAIN_EVENT;
        it.sample_stamp = stamp;
        it.event_number = number;
        it.event_flags  = flags;
        it.gain_first   = g1;
        it.gain_second  = g2;
        return it;
    endfunction

    // A valid cause (0 to 6) and kind (1 or 2) with the reserved bits clear.
    function automatic logic [15:0] good_flags();
        logic [1:0] kind;
        logic [3:0] cause;

        kind  = 2'($urandom_range(1, 2));
        cause = 4'($urandom_range(0, 6));
        return {10'd0, kind, cause};
    endfunction

    // A frame that mostly opens just past the last accepted stamp, so that
    // the following well-formed events land in it, with the occasional far
    // away, wrapping, empty or maximal frame mixed in.
    function automatic gesc_pkg::item_t random_frame(logic [63:0] near);
        logic [63:0] start;
        logic [31:0] len;
        logic [6:0]  cap;
        int unsigned pick;

        pick  = $urandom_range(0, 99);
        start = near + $urandom_range(0, 40);
        if (pick < 5)
            start = {$urandom, $urandom};
        else if (pick < 10)
            start = 64'hffff_ffff_ffff_ffff - $urandom_range(0, 300);

        len = $urandom_range(20, 200);
        case ($urandom_range(0, 19))
            0: len = '0;
            1: len = 32'd1;
            2: len = '1;
            3: len = $urandom;
            default: ;
        endcase

        // Small capacities make the capacity-full case common.
        pick = $urandom_range(0, 9);
        if (pick < 6)
            cap = 7'($urandom_range(0, 8));
        else if (pick < 8)
            cap = 7'($urandom_range(9, 64));
        else if (pick == 8)
            cap = gesc_pkg::MAX_FORWARD;
        else
            cap = 7'($urandom_range(65, 127));
        return frame_item(start, len, cap);
    endfunction

    // ------------------------------------------------------------------------
    // Sender tasks. Every task returns at a rising edge, so a following send
    // can keep s_tvalid high without lowering it in the same step.
    // ------------------------------------------------------------------------
    task automatic send_item(input gesc_pkg::item_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.operation;
        s_tdata  <= {1'b0, it.gain_second, it.gain_first, it.event_flags,
                     it.event_number, it.sample_stamp, it.frame_capacity,
                     it.frame_length, it.frame_start};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_transfer(it);
        if (it.operation == gesc_pkg::OP_BEGIN_FRAME)
            frames_sent++;
        else
            events_sent++;
        if ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // Stops offering items and waits until every predicted result has been
    // checked, then lets the pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both start registers back to back; only called while idle.
    task automatic load_registers(input logic [31:0] gain_value,
                                  input logic [31:0] count_value);
        cfg_we    <= 1'b1;
        cfg_index <= gesc_pkg::CFG_START_GAIN;
        cfg_data  <= gain_value;
        @(posedge clk);
        board.write_register(gesc_pkg::CFG_START_GAIN, gain_value);
        cfg_index <= gesc_pkg::CFG_START_COUNT;
        cfg_data  <= count_value;
        @(posedge clk);
        board.write_register(gesc_pkg::CFG_START_COUNT, count_value);
        cfg_we    <= 1'b0;
    endtask

    // Directed items: field extremes, every verdict and the special cases.
    task automatic run_directed();
        // No window has been opened yet, so the event waits.
        send_item(event_item(64'd0, 32'd5, 16'h0010, 8'd3, 8'd3));
        // Empty frame, then a frame whose end passes the top of the stamp range.
        send_item(frame_item(64'd0, 32'd0, 7'd3));
        send_item(frame_item(64'hffff_ffff_ffff_fff0, 32'h20, 7'd5));
        // Capacity above the limit saturates.
        send_item(frame_item(64'd1000, 32'd100, 7'd127));
        // Before the window: consumed. The transition count then wraps.
        send_item(event_item(64'd500, 32'd7, 16'h0010, 8'd10, 8'd10));
        send_item(event_item(64'd1000, 32'd8, 16'h0026, 8'd127, 8'd127));
        // Sequence gap, then stamp regression.
        send_item(event_item(64'd1050, 32'd10, 16'h0011, 8'd9, 8'd9));
        send_item(event_item(64'd900, 32'd9, 16'h0011, 8'd9, 8'd9));
        // Malformed events: unequal pair, gain above range, reserved flag
        // bits, kind zero, kind three and a cause above six.
        send_item(event_item(64'd1060, 32'd9, 16'h0011, 8'd5, 8'd6));
        send_item(event_item(64'd1060, 32'd9, 16'h0011, 8'd128, 8'd128));
        send_item(event_item(64'd1060, 32'd9, 16'h0050, 8'd9, 8'd9));
        send_item(event_item(64'd1060, 32'd9, 16'h8011, 8'd9, 8'd9));
        send_item(event_item(64'd1060, 32'd9, 16'h0001, 8'd9, 8'd9));
        send_item(event_item(64'd1060, 32'd9, 16'h0031, 8'd9, 8'd9));
        send_item(event_item(64'd1060, 32'd9, 16'h0017, 8'd9, 8'd9));
        // Exactly at the window end defers; the last stamp inside forwards.
        send_item(event_item(64'd1100, 32'd9, 16'h0020, 8'd0, 8'd0));
        send_item(event_item(64'd1099, 32'd9, 16'h0020, 8'd0, 8'd0));
        // Zero capacity: an in-window event finds the frame already full.
        send_item(frame_item(64'd2000, 32'd10, 7'd0));
        send_item(event_item(64'd2005, 32'd10, 16'h0024, 8'd64, 8'd64));
        // Longest frame with room for one event.
        send_item(frame_item(64'd2000, 32'hffff_ffff, 7'd1));
        send_item(event_item(64'd2005, 32'd10, 16'h0024, 8'd64, 8'd64));
        send_item(event_item(64'd2006, 32'd11, 16'h0015, 8'd1, 8'd1));
        // A window ending at the largest stamp, the largest stamp deferred,
        // and a frame one sample too long for the stamp range.
        send_item(frame_item(64'hffff_ffff_ffff_ff00, 32'hff, 7'd2));
        send_item(event_item(64'hffff_ffff_ffff_ffff, 32'd11, 16'h0015, 8'd1, 8'd1));
        send_item(frame_item(64'hffff_ffff_ffff_ff01, 32'hff, 7'd2));
    endtask

    // One random item: mostly well-formed events that continue the tracked
    // sequence, some frames, some broken events and a little pure noise.
    task automatic random_step();
        gesc_pkg::item_t it;
        logic [63:0]     base;
        logic [7:0]      g;
        int unsigned     pick;

        pick = $urandom_range(0, 99);
        base = board.track.last_stamp;
        g    = 8'($urandom_range(0, 127));
        if (pick < 4)
        begin
            it = random_item();
        end
        else if (pick < 16)
        begin
            it = random_frame(base);
        end
        else
        begin
            it = event_item(base + $urandom_range(0, 8), board.track.next_event_number,
                            good_flags(), g, g);
            if (pick >= 82)
            begin
                case ($urandom_range(0, 4))
                    0: it.event_number = it.event_number + $urandom_range(1, 3);
                    1:
                    begin
                        if (base != '0)
                            it.sample_stamp = base - $urandom_range(1, 4);
                    end
                    2: it.gain_second = it.gain_first ^ (8'd1 << $urandom_range(0, 7));
                    3:
                    begin
                        it.gain_first  = 8'($urandom_range(128, 255));
                        it.gain_second = it.gain_first;
                    end
                    default: it.event_flags = 16'($urandom);
                endcase
            end
        end
        send_item(it);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: checks every output transfer and idles at random.
    // A hold-off request keeps m_tready low for a long stretch so the block
    // fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned sink_wait;

        sink_wait = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (hold_off_req)
            begin
                sink_wait    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (sink_wait == 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                sink_wait = pick_gap();
            end
            if (sink_wait > 0)
            begin
                m_tready <= 1'b0;
                sink_wait--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int unsigned cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycles, board.expected_q.size());
        $display("** gain_event_stream_checker: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed items, four random phases with their
    // own register settings and idling, then a closing check at the top of
    // the stamp range.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        logic [7:0]  g;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = gesc_pkg::CFG_START_GAIN;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part runs with light idling and the registers near their
        // top, so that the transition count wraps early.
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        load_registers(32'd127, 32'hffff_fffe);
        run_directed();

        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    // No idling on either side.
                    load_registers(32'd0, 32'd0);
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    load_registers(32'd127, 32'hffff_fff0);
                    src_gap_pct    = 30;
                    sink_stall_pct = 30;
                end
                2:
                begin
                    // The sender streams back to back into a long receiver
                    // hold-off, which backs the block up to its input.
                    load_registers($urandom_range(0, 127), $urandom);
                    src_gap_pct    = 0;
                    sink_stall_pct = 20;
                    hold_off_req   = 1'b1;
                end
                default:
                begin
                    load_registers($urandom_range(0, 127), $urandom);
                    src_gap_pct    = 50;
                    sink_stall_pct = 50;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Midway through one phase the sender stops until all
                // outstanding results are back.
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    settle();
                random_step();
            end
        end

        // A window ending at the largest stamp takes an event just below it.
        g = 8'($urandom_range(0, 127));
        send_item(frame_item(64'hffff_ffff_ffff_ff00, 32'hff, gesc_pkg::MAX_FORWARD));
        send_item(event_item(64'hffff_ffff_ffff_fffe, board.track.next_event_number,
                             good_flags(), g, g));
        // Any result still missing keeps settle waiting until the watchdog.
        settle();

        $display("Checked %0d results for %0d begin-frame and %0d event transfers over",
                 board.results_seen, frames_sent, events_sent);
        $display({"five register settings: fwd %0d, consumed %0d, deferred %0d, ",
                  "gap %0d, regr %0d, bad %0d, full %0d, range %0d, frame %0d."},
                 board.verdict_hits[0], board.verdict_hits[1], board.verdict_hits[2],
                 board.verdict_hits[3], board.verdict_hits[4], board.verdict_hits[5],
                 board.verdict_hits[6], board.verdict_hits[7], board.verdict_hits[8]);
        if (board.mismatches == 0)
            $display("** gain_event_stream_checker: PASSED **");
        else
            $display("** gain_event_stream_checker: FAILED **");
        $finish;
    end

endmodule
